FILE: rtl/ray_triangle_intersect_core_defines.svh
// Assertion macros shared by the ray/triangle intersection RTL.
`ifndef RAY_TRIANGLE_INTERSECT_CORE_DEFINES_SVH
`define RAY_TRIANGLE_INTERSECT_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk, quiet while arst_n is low.
`define RTI_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, quiet while arst_n is low.
`define RTI_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/rti_pkg.sv
// Types and constants shared by the ray/triangle intersection modules.
`default_nettype none
package rti_pkg;
	localparam int CW          = 32;            // coordinate width
	localparam int EW          = CW + 1;        // edge and tvec width
	localparam int PW          = 2 * EW;        // pvec and qvec width
	localparam int DW          = EW + PW + 2;   // determinant and numerator width
	localparam int QB          = CW + 1;        // quotient bits before saturation
	localparam int DIV_LAT     = QB + 3;        // divider latency in cycles
	localparam int EPS_W       = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int QCW         = $clog2(QUEUE_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int ADDR_W      = $clog2(8 * 4);

	localparam logic [EPS_W-1:0] DET_EPS_RESET = 32'd281474977;

	typedef enum logic [2:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_DIR_X    = 3'd3,
		REG_DIR_Y    = 3'd4,
		REG_DIR_Z    = 3'd5,
		REG_CULL     = 3'd6,
		REG_DET_EPS  = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		RSN_HIT = 2'd0,
		RSN_DET = 2'd1,
		RSN_U   = 2'd2,
		RSN_V   = 2'd3
	} reason_t;

	typedef struct packed {
		logic signed [CW-1:0] v0_x;
		logic signed [CW-1:0] v0_y;
		logic signed [CW-1:0] v0_z;
		logic signed [CW-1:0] v1_x;
		logic signed [CW-1:0] v1_y;
		logic signed [CW-1:0] v1_z;
		logic signed [CW-1:0] v2_x;
		logic signed [CW-1:0] v2_y;
		logic signed [CW-1:0] v2_z;
	} tri_t;

	typedef struct packed {
		logic                 hit;
		logic [1:0]           miss_reason;
		logic signed [CW-1:0] bary_u;
		logic signed [CW-1:0] bary_v;
		logic signed [CW-1:0] ray_distance;
	} result_t;

	typedef struct packed {
		logic signed [CW-1:0] org_x;
		logic signed [CW-1:0] org_y;
		logic signed [CW-1:0] org_z;
		logic signed [CW-1:0] dir_x;
		logic signed [CW-1:0] dir_y;
		logic signed [CW-1:0] dir_z;
		logic                 cull;
		logic [EPS_W-1:0]     eps;
	} ray_cfg_t;

	typedef struct packed {
		reason_t              reason;
		logic                 cull;
		logic signed [DW-1:0] det;
		logic signed [DW-1:0] un;
		logic signed [DW-1:0] vn;
		logic signed [DW-1:0] tn;
	} q_entry_t;

	typedef struct packed {
		logic           full;
		logic           empty;
		logic [QCW-1:0] count;
	} q_stat_t;
endpackage
`default_nettype wire

FILE: rtl/rti_div.sv
// Pipelined signed divider: (num << FRAC_BITS) / den, truncated, saturated.
`default_nettype none
module rti_div #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                             clk,
	input  wire logic                             en,
	input  wire logic signed [rti_pkg::DW-1:0]    num,
	input  wire logic signed [rti_pkg::DW-1:0]    den,
	output logic signed [rti_pkg::CW-1:0]         quo
);
	localparam int CW = rti_pkg::CW;
	localparam int DW = rti_pkg::DW;
	localparam int QB = rti_pkg::QB;
	localparam int NW = DW + FRAC_BITS;
	localparam int RW = (DW + QB > NW) ? DW + QB : NW;

	localparam logic [QB-1:0] Q_MAX     = {2'b00, {(CW-1){1'b1}}};
	localparam logic [QB-1:0] Q_MIN_MAG = {2'b01, {(CW-1){1'b0}}};
	localparam logic [CW-1:0] OUT_MAX   = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] OUT_MIN   = {1'b1, {(CW-1){1'b0}}};

	logic [DW-1:0] nabs, dabs;
	logic [RW-1:0] n_a;
	logic [DW-1:0] d_a;
	logic          neg_a;

	logic [RW-1:0] rem_r [QB+1];
	logic [QB-1:0] q_r   [QB+1];
	logic [DW-1:0] d_r   [QB+1];
	logic          neg_r [QB+1];
	logic          ovf_r [QB+1];
	logic [RW:0]   sub_c [QB];

	assign nabs = num[DW-1] ? DW'(-num) : DW'(num);
	assign dabs = den[DW-1] ? DW'(-den) : DW'(den);

	// trial subtract of the shifted divisor, one quotient bit per stage
	always_comb begin
		for (int k = 0; k < QB; k++) begin
			sub_c[k] = {1'b0, rem_r[k]} - ({1'b0, RW'(d_r[k])} << (QB - 1 - k));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_a   <= RW'({nabs, {FRAC_BITS{1'b0}}});
			d_a   <= dabs;
			neg_a <= num[DW-1] ^ den[DW-1];

			rem_r[0] <= n_a;
			q_r[0]   <= '0;
			d_r[0]   <= d_a;
			neg_r[0] <= neg_a;
			ovf_r[0] <= n_a >= (RW'(d_a) << QB);

			for (int k = 0; k < QB; k++) begin
				rem_r[k+1] <= sub_c[k][RW] ? rem_r[k] : sub_c[k][RW-1:0];
				q_r[k+1]   <= {q_r[k][QB-2:0], ~sub_c[k][RW]};
				d_r[k+1]   <= d_r[k];
				neg_r[k+1] <= neg_r[k];
				ovf_r[k+1] <= ovf_r[k];
			end

			if (neg_r[QB]) begin
				if (ovf_r[QB] || q_r[QB] > Q_MIN_MAG) begin
					quo <= OUT_MIN;
				end else begin
					quo <= CW'(~q_r[QB] + QB'(1));
				end
			end else begin
				if (ovf_r[QB] || q_r[QB] > Q_MAX) begin
					quo <= OUT_MAX;
				end else begin
					quo <= CW'(q_r[QB]);
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/rti_front.sv
// Front pipeline: edges, cross and dot products, determinant tests.
`default_nettype none
module rti_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire rti_pkg::tri_t      in_data,
	input  wire rti_pkg::ray_cfg_t  cfg,
	output logic                    out_valid,
	output rti_pkg::q_entry_t       out_data
);
	localparam int CW  = rti_pkg::CW;
	localparam int EW  = rti_pkg::EW;
	localparam int PW  = rti_pkg::PW;
	localparam int DW  = rti_pkg::DW;
	localparam int HB  = EW;
	localparam int HPW = 2 * EW;
	localparam int LPW = 2 * EW + 1;
	localparam int NX [3] = '{1, 2, 0};
	localparam int NN [3] = '{2, 0, 1};

	logic signed [CW-1:0] v0 [3], v1 [3], v2 [3], org [3], dir [3];

	logic signed [EW-1:0] e1_s1 [3], e2_s1 [3], tv_s1 [3], d_s1 [3];
	logic signed [EW-1:0] e1_s2 [3], e2_s2 [3], tv_s2 [3], d_s2 [3];
	logic signed [EW-1:0] e1_s3 [3], e2_s3 [3], tv_s3 [3], d_s3 [3];
	logic signed [PW-1:0] pva_s2 [3], pvb_s2 [3], qva_s2 [3], qvb_s2 [3];
	logic signed [PW-1:0] pv_s3 [3], qv_s3 [3];

	logic signed [EW-1:0]  aop [4][3];
	logic signed [PW-1:0]  vop [4][3];
	logic signed [HPW-1:0] dh_s4 [4][3];
	logic signed [LPW-1:0] dl_s4 [4][3];
	logic signed [DW-1:0]  prod_s5 [4][3];
	logic signed [DW-1:0]  dot_s6 [4];

	logic signed [DW-1:0] det_s7, un_s7, vn_s7, tn_s7, uv_s7;
	logic det_zero_s7, lt_eps_s7, gt_neps_s7, un_neg_s7, det_lt_un_s7, vn_neg_s7;
	logic signed [DW-1:0] eps_ext;

	rti_pkg::reason_t  rsn_c;
	rti_pkg::q_entry_t entry_s8;
	logic [7:0]        vld_q;

	always_comb begin
		v0  = '{in_data.v0_x, in_data.v0_y, in_data.v0_z};
		v1  = '{in_data.v1_x, in_data.v1_y, in_data.v1_z};
		v2  = '{in_data.v2_x, in_data.v2_y, in_data.v2_z};
		org = '{cfg.org_x, cfg.org_y, cfg.org_z};
		dir = '{cfg.dir_x, cfg.dir_y, cfg.dir_z};
	end

	// dot operand pairs: det = e1.pv, un = tv.pv, vn = d.qv, tn = e2.qv
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			aop[0][i] = e1_s3[i];
			vop[0][i] = pv_s3[i];
			aop[1][i] = tv_s3[i];
			vop[1][i] = pv_s3[i];
			aop[2][i] = d_s3[i];
			vop[2][i] = qv_s3[i];
			aop[3][i] = e2_s3[i];
			vop[3][i] = qv_s3[i];
		end
	end

	assign eps_ext = DW'($signed({1'b0, cfg.eps}));

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= EW'(v1[i]) - EW'(v0[i]);
				e2_s1[i] <= EW'(v2[i]) - EW'(v0[i]);
				tv_s1[i] <= EW'(org[i]) - EW'(v0[i]);
				d_s1[i]  <= EW'(dir[i]);

				pva_s2[i] <= PW'(d_s1[NX[i]]) * PW'(e2_s1[NN[i]]);
				pvb_s2[i] <= PW'(d_s1[NN[i]]) * PW'(e2_s1[NX[i]]);
				qva_s2[i] <= PW'(tv_s1[NX[i]]) * PW'(e1_s1[NN[i]]);
				qvb_s2[i] <= PW'(tv_s1[NN[i]]) * PW'(e1_s1[NX[i]]);
				e1_s2[i]  <= e1_s1[i];
				e2_s2[i]  <= e2_s1[i];
				tv_s2[i]  <= tv_s1[i];
				d_s2[i]   <= d_s1[i];

				pv_s3[i] <= pva_s2[i] - pvb_s2[i];
				qv_s3[i] <= qva_s2[i] - qvb_s2[i];
				e1_s3[i] <= e1_s2[i];
				e2_s3[i] <= e2_s2[i];
				tv_s3[i] <= tv_s2[i];
				d_s3[i]  <= d_s2[i];
			end

			// split the wide operand into a signed high and unsigned low half
			for (int k = 0; k < 4; k++) begin
				for (int i = 0; i < 3; i++) begin
					dh_s4[k][i] <= HPW'(aop[k][i]) * HPW'($signed(vop[k][i][PW-1:HB]));
					dl_s4[k][i] <= LPW'(aop[k][i]) *
						LPW'($signed({1'b0, vop[k][i][HB-1:0]}));
					prod_s5[k][i] <= (DW'(dh_s4[k][i]) <<< HB) + DW'(dl_s4[k][i]);
				end
				dot_s6[k] <= prod_s5[k][0] + prod_s5[k][1] + prod_s5[k][2];
			end

			det_s7       <= dot_s6[0];
			un_s7        <= dot_s6[1];
			vn_s7        <= dot_s6[2];
			tn_s7        <= dot_s6[3];
			uv_s7        <= dot_s6[1] + dot_s6[2];
			det_zero_s7  <= dot_s6[0] == '0;
			lt_eps_s7    <= dot_s6[0] < eps_ext;
			gt_neps_s7   <= dot_s6[0] > -eps_ext;
			un_neg_s7    <= dot_s6[1][DW-1];
			vn_neg_s7    <= dot_s6[2][DW-1];
			det_lt_un_s7 <= dot_s6[0] < dot_s6[1];

			entry_s8.reason <= rsn_c;
			entry_s8.cull   <= cfg.cull;
			entry_s8.det    <= det_s7;
			entry_s8.un     <= un_s7;
			entry_s8.vn     <= vn_s7;
			entry_s8.tn     <= tn_s7;
		end
	end

	// culling mode settles everything here; two-sided mode only the parallel case
	always_comb begin
		rsn_c = rti_pkg::RSN_HIT;
		if (det_zero_s7) begin
			rsn_c = rti_pkg::RSN_DET;
		end else if (cfg.cull) begin
			if (lt_eps_s7) begin
				rsn_c = rti_pkg::RSN_DET;
			end else if (un_neg_s7 || det_lt_un_s7) begin
				rsn_c = rti_pkg::RSN_U;
			end else if (vn_neg_s7 || (det_s7 < uv_s7)) begin
				rsn_c = rti_pkg::RSN_V;
			end
		end else if (gt_neps_s7 && lt_eps_s7) begin
			rsn_c = rti_pkg::RSN_DET;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[6:0], in_valid};
		end
	end

	assign out_valid = vld_q[7];
	assign out_data  = entry_s8;
endmodule
`default_nettype wire

FILE: rtl/rti_queue.sv
// Short FIFO between the front and back pipelines.
`default_nettype none
module rti_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire rti_pkg::q_entry_t  wdata,
	input  wire logic               pop,
	output rti_pkg::q_entry_t       rdata,
	output rti_pkg::q_stat_t        stat
);
	localparam int DEPTH = rti_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int QCW   = rti_pkg::QCW;

	rti_pkg::q_entry_t    slot_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0]       count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

	assign rdata      = slot_q[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.full  = count_q == QCW'(DEPTH);
	assign stat.empty = count_q == '0;
endmodule
`default_nettype wire

FILE: rtl/rti_back.sv
// Back pipeline: three dividers, two-sided range tests, output skid buffer.
`default_nettype none
module rti_back #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire rti_pkg::q_entry_t  in_data,
	output logic                    in_pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output rti_pkg::result_t        out_data
);
	localparam int CW  = rti_pkg::CW;
	localparam int LAT = rti_pkg::DIV_LAT;
	localparam logic signed [CW:0] ONE_Q = (CW+1)'(1 << FRAC_BITS);

	logic                  en;
	logic signed [CW-1:0]  uq, vq, tq;
	logic signed [CW:0]    uv_sum;
	logic [LAT-1:0]        vld_q;
	rti_pkg::reason_t      rsn_p [LAT];
	logic                  cull_p [LAT];
	rti_pkg::reason_t      rsn_c;
	rti_pkg::result_t      res_c, out_q, spare_q;
	logic                  out_valid_q, spare_valid_q, push;

	// the whole back pipeline holds only while the spare slot is occupied
	assign en     = ~spare_valid_q;
	assign in_pop = in_valid & en;

	rti_div #(.FRAC_BITS(FRAC_BITS)) u_div_u (
		.clk (clk), .en (en), .num (in_data.un), .den (in_data.det), .quo (uq)
	);
	rti_div #(.FRAC_BITS(FRAC_BITS)) u_div_v (
		.clk (clk), .en (en), .num (in_data.vn), .den (in_data.det), .quo (vq)
	);
	rti_div #(.FRAC_BITS(FRAC_BITS)) u_div_t (
		.clk (clk), .en (en), .num (in_data.tn), .den (in_data.det), .quo (tq)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			rsn_p[0]  <= in_data.reason;
			cull_p[0] <= in_data.cull;
			for (int k = 1; k < LAT; k++) begin
				rsn_p[k]  <= rsn_p[k-1];
				cull_p[k] <= cull_p[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	assign uv_sum = (CW+1)'(uq) + (CW+1)'(vq);

	always_comb begin
		rsn_c = rsn_p[LAT-1];
		if (rsn_p[LAT-1] == rti_pkg::RSN_HIT && !cull_p[LAT-1]) begin
			if (uq < 0 || (CW+1)'(uq) > ONE_Q) begin
				rsn_c = rti_pkg::RSN_U;
			end else if (vq < 0 || uv_sum > ONE_Q) begin
				rsn_c = rti_pkg::RSN_V;
			end
		end
		res_c.hit          = rsn_c == rti_pkg::RSN_HIT;
		res_c.miss_reason  = rsn_c;
		res_c.bary_u       = res_c.hit ? uq : '0;
		res_c.bary_v       = res_c.hit ? vq : '0;
		res_c.ray_distance = res_c.hit ? tq : '0;
	end

	assign push = vld_q[LAT-1] & en;

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_q <= spare_valid_q ? spare_q : res_c;
		end else if (push) begin
			spare_q <= res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			spare_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q   <= spare_valid_q | push;
			spare_valid_q <= 1'b0;
		end else if (push) begin
			spare_valid_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule
`default_nettype wire

FILE: rtl/ray_triangle_intersect_core.sv
// Top level of the Moller-Trumbore ray/triangle intersection core.
//
// One ray (origin, direction, cull mode, determinant threshold) sits in the
// APB registers and triangles stream in on the tri channel, one transaction
// per triangle; each yields exactly one result transaction in order: hit flag,
// miss reason, barycentric u and v and distance t, all Q16.16, saturated, and
// zero on a miss. The core takes a new triangle every cycle while tri_ready
// is high. A triangle passes 8 front stages (edges, cross products, split
// 33x66 dot products, determinant tests), a 4-entry queue, 36 divider stages
// (operand set-up, one quotient bit per stage, saturation) and the output
// register. Front and back stall on their own; a skid slot lets the back
// pipeline take one more result while the output is held. Write the registers
// only while no triangle is in flight.
`default_nettype none
`include "ray_triangle_intersect_core_defines.svh"
module ray_triangle_intersect_core #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [rti_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [rti_pkg::DATA_W-1:0]    pwdata,
	output logic [rti_pkg::DATA_W-1:0]         prdata,
	output logic                               pready,
	input  wire logic                          tri_valid,
	output logic                               tri_ready,
	input  wire rti_pkg::tri_t                 tri_data,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output rti_pkg::result_t                   res_data
);
	localparam int CW     = rti_pkg::CW;
	localparam int DATA_W = rti_pkg::DATA_W;
	localparam int ADDR_W = rti_pkg::ADDR_W;

	rti_pkg::ray_cfg_t cfg_q;
	logic [2:0]        reg_idx;
	logic              cfg_wr;

	logic              front_valid, front_en;
	rti_pkg::q_entry_t front_data, q_head;
	rti_pkg::q_stat_t  q_stat;
	logic              q_push, q_pop;

	// register index sits above the byte offset
	assign reg_idx = paddr[ADDR_W-1:2];
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.org_x <= '0;
			cfg_q.org_y <= '0;
			cfg_q.org_z <= '0;
			cfg_q.dir_x <= '0;
			cfg_q.dir_y <= '0;
			cfg_q.dir_z <= CW'(1 << FRAC_BITS);
			cfg_q.cull  <= 1'b0;
			cfg_q.eps   <= rti_pkg::DET_EPS_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				rti_pkg::REG_ORIGIN_X: cfg_q.org_x <= CW'(pwdata);
				rti_pkg::REG_ORIGIN_Y: cfg_q.org_y <= CW'(pwdata);
				rti_pkg::REG_ORIGIN_Z: cfg_q.org_z <= CW'(pwdata);
				rti_pkg::REG_DIR_X:    cfg_q.dir_x <= CW'(pwdata);
				rti_pkg::REG_DIR_Y:    cfg_q.dir_y <= CW'(pwdata);
				rti_pkg::REG_DIR_Z:    cfg_q.dir_z <= CW'(pwdata);
				rti_pkg::REG_CULL:     cfg_q.cull  <= pwdata[0];
				rti_pkg::REG_DET_EPS:  cfg_q.eps   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			rti_pkg::REG_ORIGIN_X: prdata = DATA_W'(cfg_q.org_x);
			rti_pkg::REG_ORIGIN_Y: prdata = DATA_W'(cfg_q.org_y);
			rti_pkg::REG_ORIGIN_Z: prdata = DATA_W'(cfg_q.org_z);
			rti_pkg::REG_DIR_X:    prdata = DATA_W'(cfg_q.dir_x);
			rti_pkg::REG_DIR_Y:    prdata = DATA_W'(cfg_q.dir_y);
			rti_pkg::REG_DIR_Z:    prdata = DATA_W'(cfg_q.dir_z);
			rti_pkg::REG_CULL:     prdata = DATA_W'(cfg_q.cull);
			rti_pkg::REG_DET_EPS:  prdata = DATA_W'(cfg_q.eps);
			default:               prdata = '0;
		endcase
	end

	// hold the whole front pipeline only when its last stage cannot enter the queue
	assign front_en  = ~(front_valid & q_stat.full);
	assign tri_ready = front_en;
	assign q_push    = front_valid & ~q_stat.full;

	rti_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (front_en),
		.in_valid  (tri_valid),
		.in_data   (tri_data),
		.cfg       (cfg_q),
		.out_valid (front_valid),
		.out_data  (front_data)
	);

	rti_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (front_data),
		.pop    (q_pop),
		.rdata  (q_head),
		.stat   (q_stat)
	);

	rti_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (~q_stat.empty),
		.in_data   (q_head),
		.in_pop    (q_pop),
		.out_valid (res_valid),
		.out_ready (res_ready),
		.out_data  (res_data)
	);

	`RTI_ASSERT_NEXT(a_queue_fills, q_push && !q_pop && (q_stat.count == (rti_pkg::QUEUE_DEPTH - 1)), q_stat.full, "queue did not report full after last free slot was taken")
	`RTI_ASSERT_NEXT(a_queue_drains, q_pop && !q_push && (q_stat.count == 1), q_stat.empty, "queue did not report empty after last entry left")
	`RTI_ASSERT_IMPL(a_miss_zero, res_valid && !res_data.hit, (res_data.bary_u == '0) && (res_data.bary_v == '0) && (res_data.ray_distance == '0), "miss transaction carries nonzero coordinates")
endmodule
`default_nettype wire
